// ===== hdl/bda_pkg.sv =====
`default_nettype none

package bda_pkg;

  localparam int MaxButtons = 8;
  localparam int MaxEvents  = 4;
  localparam int PinWidth   = 4;
  localparam int IndexWidth = 2;
  localparam int CountWidth = 8;
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DELAY    = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_NONE     = 2'd3
  } reg_index_t;

  // events of one tick, one bit per button
  typedef struct packed {
    logic [MaxButtons-1:0] fire;
    logic [MaxButtons-1:0] press;
    logic [MaxButtons-1:0] rep;
  } tick_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== hdl/button_debounce_autorepeat_top.sv =====
// The first event of a tick passes through the queue, the event register and the output register.
// Ticks enter a 4-entry queue at one per cycle while it is not full; the event stage
// loads each tick with events and then emits its events one by one (up to 4).
// A tick is accepted whenever the queue is not full.
// Reset (rst, synchronous): all buttons up, counts zero, registers 5/50/10.
`default_nettype none

module button_debounce_autorepeat_top import bda_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [IndexWidth-1:0] cfg_index,
  input  wire logic [CountWidth-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PinWidth-1:0]   pin_levels,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IndexWidth-1:0]      button_index,
  output logic                       is_press,
  output logic                       is_repeat,
  output logic                       last_event
);

  tick_rec_t     push_rec;
  tick_rec_t     head_rec;
  logic          push;
  logic          pop;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;

  bda_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (in_valid && in_ready),
    .pin_levels (pin_levels),
    .rec        (push_rec),
    .push       (push)
  );

  bda_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .status   (q_status)
  );

  bda_back #(.NUM_BUTTONS(NUM_BUTTONS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head_rec     (head_rec),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_index (button_index),
    .is_press     (is_press),
    .is_repeat    (is_repeat),
    .last_event   (last_event)
  );

  a_repeat_is_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_repeat |-> is_press)
    else $error("repeat event without press");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_tick_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_event |=> out_valid)
    else $error("tick events interrupted");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/bda_front.sv =====
`default_nettype none

module bda_front import bda_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [IndexWidth-1:0] cfg_index,
  input  wire logic [CountWidth-1:0] cfg_data,
  input  wire logic                  accept,
  input  wire logic [PinWidth-1:0]   pin_levels,
  output tick_rec_t                  rec,
  output logic                       push
);

  typedef enum logic [1:0] {
    ST_UP       = 2'd0,
    ST_DEBOUNCE = 2'd1,
    ST_DELAY    = 2'd2,
    ST_REPEAT   = 2'd3
  } stage_t;

  logic [CountWidth-1:0] debounce_ticks;
  logic [CountWidth-1:0] delay_ticks;
  logic [CountWidth-1:0] repeat_ticks;

  stage_t                stage      [NUM_BUTTONS];
  stage_t                stage_next [NUM_BUTTONS];
  logic [CountWidth-1:0] count      [NUM_BUTTONS];
  logic [CountWidth-1:0] count_next [NUM_BUTTONS];

  logic [MaxButtons-1:0] pins_ext;

  // buttons past the pin width read as pressed
  assign pins_ext = MaxButtons'(pin_levels);

  always_comb begin
    rec = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      stage_next[i] = stage[i];
      count_next[i] = count[i];
      if (!pins_ext[i]) begin
        unique case (stage[i])
          ST_UP: begin
            stage_next[i] = ST_DEBOUNCE;
            count_next[i] = CountWidth'(1);
          end
          ST_DEBOUNCE: begin
            if (count[i] >= debounce_ticks) begin
              stage_next[i] = ST_DELAY;
              count_next[i] = '0;
              rec.fire[i]   = 1'b1;
              rec.press[i]  = 1'b1;
            end else begin
              count_next[i] = count[i] + CountWidth'(1);
            end
          end
          ST_DELAY: begin
            if (count[i] >= delay_ticks) begin
              stage_next[i] = ST_REPEAT;
              count_next[i] = '0;
              rec.fire[i]   = 1'b1;
              rec.press[i]  = 1'b1;
              rec.rep[i]    = 1'b1;
            end else begin
              count_next[i] = count[i] + CountWidth'(1);
            end
          end
          ST_REPEAT: begin
            if (count[i] >= repeat_ticks) begin
              count_next[i] = '0;
              rec.fire[i]   = 1'b1;
              rec.press[i]  = 1'b1;
              rec.rep[i]    = 1'b1;
            end else begin
              count_next[i] = count[i] + CountWidth'(1);
            end
          end
          default: ;
        endcase
      end else begin
        stage_next[i] = ST_UP;
        if (stage[i] == ST_DELAY || stage[i] == ST_REPEAT) begin
          rec.fire[i] = 1'b1;
        end
      end
    end
  end

  assign push = accept && (rec.fire != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= CountWidth'(5);
      delay_ticks    <= CountWidth'(50);
      repeat_ticks   <= CountWidth'(10);
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_DEBOUNCE: debounce_ticks <= cfg_data;
        REG_DELAY:    delay_ticks    <= cfg_data;
        REG_REPEAT:   repeat_ticks   <= cfg_data;
        REG_NONE:     ;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (rst) begin
        stage[i] <= ST_UP;
        count[i] <= '0;
      end else if (accept) begin
        stage[i] <= stage_next[i];
        count[i] <= count_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bda_queue.sv =====
`default_nettype none

module bda_queue import bda_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire tick_rec_t push_rec,
  input  wire logic  pop,
  output tick_rec_t  head_rec,
  output queue_status_t status
);

  localparam int AddrWidth = $clog2(QueueDepth);

  tick_rec_t              mem [QueueDepth];
  logic [AddrWidth-1:0]   wr_ptr;
  logic [AddrWidth-1:0]   rd_ptr;
  logic [AddrWidth:0]     fill;

  assign status.full  = (fill == (AddrWidth+1)'(QueueDepth));
  assign status.empty = (fill == '0);
  assign head_rec     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !status.full) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !status.full) begin
        wr_ptr <= wr_ptr + AddrWidth'(1);
      end
      if (pop && !status.empty) begin
        rd_ptr <= rd_ptr + AddrWidth'(1);
      end
      unique case ({push && !status.full, pop && !status.empty})
        2'b10:   fill <= fill + (AddrWidth+1)'(1);
        2'b01:   fill <= fill - (AddrWidth+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bda_back.sv =====
`default_nettype none

module bda_back import bda_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire queue_status_t         q_status,
  input  wire tick_rec_t             head_rec,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IndexWidth-1:0]      button_index,
  output logic                       is_press,
  output logic                       is_repeat,
  output logic                       last_event
);

  localparam int SelWidth = $clog2(MaxButtons);
  localparam int EvWidth  = $clog2(MaxEvents);

  logic                  busy;
  tick_rec_t             cur;
  logic [EvWidth-1:0]    emitted;

  logic [MaxButtons-1:0] low_bit;
  logic [MaxButtons-1:0] remaining;
  logic [SelWidth-1:0]   sel;
  logic                  found;
  logic                  take;
  logic                  sel_last;

  always_comb begin
    low_bit = '0;
    sel     = '0;
    found   = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (cur.fire[i] && !found) begin
        found      = 1'b1;
        low_bit[i] = 1'b1;
        sel        = SelWidth'(i);
      end
    end
  end

  assign remaining = cur.fire & ~low_bit;
  assign sel_last  = (remaining == '0) || (emitted == EvWidth'(MaxEvents - 1));
  assign take      = busy && (!out_valid || out_ready);
  assign pop       = !busy && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      emitted   <= '0;
    end else begin
      if (take) begin
        out_valid    <= 1'b1;
        button_index <= IndexWidth'(sel);
        is_press     <= cur.press[sel];
        is_repeat    <= cur.rep[sel];
        last_event   <= sel_last;
        cur.fire     <= remaining;
        emitted      <= emitted + EvWidth'(1);
        if (sel_last) begin
          busy <= 1'b0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy    <= 1'b1;
        cur     <= head_rec;
        emitted <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/button_debounce_autorepeat_top_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_autorepeat_top_tb;
  import bda_pkg::*;

  localparam int NumButtons  = 4;
  localparam int DrainCycles = 24;
  localparam int HoldCycles  = 80;

  typedef enum logic [1:0] {
    ST_UP       = 2'd0,
    ST_DEBOUNCE = 2'd1,
    ST_DELAY    = 2'd2,
    ST_REPEAT   = 2'd3
  } key_stage_t;

  typedef struct packed {
    logic [IndexWidth-1:0] idx;
    logic                  press;
    logic                  rep;
    logic                  last;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IndexWidth-1:0] cfg_index;
  logic [CountWidth-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [PinWidth-1:0]   pin_levels;
  logic                  out_valid;
  logic                  out_ready;
  logic [IndexWidth-1:0] button_index;
  logic                  is_press;
  logic                  is_repeat;
  logic                  last_event;

  // key state tracker
  key_stage_t            key_stage[NumButtons];
  logic [CountWidth-1:0] hold_cnt[NumButtons];
  logic [CountWidth-1:0] debounce_lim;
  logic [CountWidth-1:0] delay_lim;
  logic [CountWidth-1:0] repeat_lim;
  key_event_t            pending_events[$];

  logic steady;
  logic hold_request;
  int   errors;
  int   ticks_sent;
  int   events_seen;
  int   presses_seen;
  int   repeats_seen;
  int   releases_seen;
  int   input_stalls;
  int   settings_used;
  int   ready_left;

  button_debounce_autorepeat_top #(
    .NUM_BUTTONS(NumButtons)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pin_levels(pin_levels),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .button_index(button_index),
    .is_press(is_press),
    .is_repeat(is_repeat),
    .last_event(last_event)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic predict_tick(input logic [PinWidth-1:0] pins);
    key_event_t ev_buf[MaxEvents];
    int         n;
    logic       fire;
    logic       rep;
    n = 0;
    for (int i = 0; i < NumButtons; i++) begin
      if (!pins[i]) begin
        fire = 1'b0;
        rep  = 1'b1;
        if (key_stage[i] == ST_REPEAT && hold_cnt[i] >= repeat_lim) begin
          fire = 1'b1;
        end else if (key_stage[i] == ST_DELAY && hold_cnt[i] >= delay_lim) begin
          key_stage[i] = ST_REPEAT;
          fire = 1'b1;
        end else if (key_stage[i] == ST_DEBOUNCE && hold_cnt[i] >= debounce_lim) begin
          key_stage[i] = ST_DELAY;
          rep = 1'b0;
          fire = 1'b1;
        end else if (key_stage[i] == ST_UP) begin
          key_stage[i] = ST_DEBOUNCE;
          hold_cnt[i] = CountWidth'(1);
        end else begin
          hold_cnt[i] = hold_cnt[i] + CountWidth'(1);
        end
        if (fire) begin
          ev_buf[n] = '{idx: i[IndexWidth-1:0], press: 1'b1, rep: rep, last: 1'b0};
          n++;
          hold_cnt[i] = '0;
        end
      end else if (key_stage[i] != ST_UP) begin
        // a bounce caught in debounce is dropped silently
        if (key_stage[i] != ST_DEBOUNCE) begin
          ev_buf[n] = '{idx: i[IndexWidth-1:0], press: 1'b0, rep: 1'b0, last: 1'b0};
          n++;
        end
        key_stage[i] = ST_UP;
      end
    end
    if (n > 0) ev_buf[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_events.push_back(ev_buf[k]);
  endtask

  task automatic send_tick(input logic [PinWidth-1:0] pins);
    int gap;
    in_valid   = 1'b1;
    pin_levels = pins;
    do @(posedge clk); while (!in_ready);
    predict_tick(pins);
    ticks_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid   = 1'b0;
      pin_levels = PinWidth'($urandom_range(0, 15));
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    // ticks without events are not queued by the block
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_register(input reg_index_t idx, input logic [CountWidth-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: debounce_lim = value;
      REG_DELAY:    delay_lim    = value;
      REG_REPEAT:   repeat_lim   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [CountWidth-1:0] d, input logic [CountWidth-1:0] dl,
                               input logic [CountWidth-1:0] r);
    wait_idle();
    set_register(REG_DEBOUNCE, d);
    set_register(REG_DELAY, dl);
    set_register(REG_REPEAT, r);
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    steady = 1'b1;
    send_tick(4'hF);
    repeat (3) send_tick(4'b1101);
    send_tick(4'hF);
    repeat (6) send_tick(4'b1110);
    send_tick(4'hF);
    steady = 1'b0;
  endtask

  task automatic test_zero_thresholds();
    apply_setting(8'd0, 8'd0, 8'd0);
    set_register(REG_NONE, 8'hFF);
    repeat (4) send_tick(4'h0);
    send_tick(4'hF);
    repeat (3) send_tick(4'b1010);
    repeat (2) send_tick(4'b0101);
  endtask

  task automatic test_random_phase(input logic [CountWidth-1:0] d,
                                   input logic [CountWidth-1:0] dl,
                                   input logic [CountWidth-1:0] r,
                                   input int n_items, input int max_hold);
    int                  sent;
    int                  run;
    int                  bit_pos;
    logic [PinWidth-1:0] held;
    logic [PinWidth-1:0] pins;
    apply_setting(d, dl, r);
    sent = 0;
    while (sent < n_items) begin
      held = PinWidth'($urandom_range(0, 15));
      run  = $urandom_range(1, max_hold);
      if (run > n_items - sent) run = n_items - sent;
      if ($urandom_range(0, 4) == 0) begin
        repeat (run) begin
          send_tick(PinWidth'($urandom_range(0, 15)));
          sent++;
        end
      end else begin
        repeat (run) begin
          pins = ~held;
          if ($urandom_range(0, 9) == 0) begin
            bit_pos = $urandom_range(0, NumButtons - 1);
            pins[bit_pos] = ~pins[bit_pos];
          end
          send_tick(pins);
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    apply_setting(8'd0, 8'd0, 8'd0);
    steady = 1'b1;
    hold_request = 1'b1;
    @(negedge clk);
    // held keys fire on every tick after their first with zero thresholds
    for (int k = 0; k < 12; k++) send_tick((k == 11) ? 4'hF : 4'h0);
    steady = 1'b0;
  endtask

  // receiver pacing
  initial begin
    out_ready  = 1'b0;
    ready_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end else if (steady) begin
        out_ready = 1'b1;
      end else if (ready_left > 0) begin
        ready_left--;
      end else begin
        out_ready  = ~out_ready;
        ready_left = out_ready ? $urandom_range(0, 10) : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_ready) input_stalls++;
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected word idx=%0d press=%0b rep=%0b last=%0b", $time,
                   button_index, is_press, is_repeat, last_event);
          errors++;
        end else begin
          automatic key_event_t want = pending_events.pop_front();
          automatic key_event_t got = '{button_index, is_press, is_repeat, last_event};
          if (got !== want) begin
            $display("%0t: mismatch expected idx=%0d press=%0b rep=%0b last=%0b", $time,
                     want.idx, want.press, want.rep, want.last);
            $display("%0t:          actual   idx=%0d press=%0b rep=%0b last=%0b", $time,
                     got.idx, got.press, got.rep, got.last);
            errors++;
          end
          events_seen++;
          if (!want.press) releases_seen++;
          else if (want.rep) repeats_seen++;
          else presses_seen++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("button_debounce_autorepeat_top_tb NOT OK");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    pin_levels    = '1;
    steady        = 1'b0;
    hold_request  = 1'b0;
    errors        = 0;
    ticks_sent    = 0;
    events_seen   = 0;
    presses_seen  = 0;
    repeats_seen  = 0;
    releases_seen = 0;
    input_stalls  = 0;
    settings_used = 0;
    debounce_lim  = 8'd5;
    delay_lim     = 8'd50;
    repeat_lim    = 8'd10;
    for (int i = 0; i < NumButtons; i++) begin
      key_stage[i] = ST_UP;
      hold_cnt[i]  = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_zero_thresholds();
    test_random_phase(8'd1, 8'd2, 8'd1, 35, 12);
    test_random_phase(CountWidth'($urandom_range(0, 4)), CountWidth'($urandom_range(0, 4)),
                      CountWidth'($urandom_range(0, 4)), 35, 12);
    test_random_phase(8'd0, 8'd3, 8'd0, 35, 16);
    test_random_phase(8'd255, 8'd0, 8'd255, 15, 8);
    test_random_phase(8'd0, 8'd255, 8'd255, 15, 8);
    test_backpressure();
    wait_idle();

    $display("ran %0d ticks over %0d register settings; %0d input stall cycles",
             ticks_sent, settings_used, input_stalls);
    $display("checked %0d events: %0d first presses, %0d repeats, %0d releases",
             events_seen, presses_seen, repeats_seen, releases_seen);
    if (errors == 0) begin
      $display("button_debounce_autorepeat_top_tb OK");
    end else begin
      $display("button_debounce_autorepeat_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bda_pkg.sv
hdl/bda_front.sv
hdl/bda_queue.sv
hdl/bda_back.sv
hdl/button_debounce_autorepeat_top.sv
tb/button_debounce_autorepeat_top_tb.sv
